@@ rtl/core/tmr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_pkg
// Shared constants, codes and types of the Turing machine runner.
// ----------------------------------------------------------------------------
package tmr_pkg;

	// machine geometry
	localparam int NUM_STATES     = 16;
	localparam int SYMBOL_BITS    = 8;
	localparam int STEP_BITS      = 20;
	localparam int TAPE_CELLS_DEF = 1024;

	localparam int STATE_W     = $clog2(NUM_STATES);
	localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
	localparam int RULE_DEPTH  = NUM_STATES * SYM_COUNT;
	localparam int RULE_AW     = $clog2(RULE_DEPTH);
	localparam int EPOCH_BITS  = 6;

	// port field widths
	localparam int MODE_FW  = 3;
	localparam int STATE_FW = 4;
	localparam int SYM_FW   = 8;
	localparam int MOVE_FW  = 2;
	localparam int KIND_FW  = 2;
	localparam int VERD_FW  = 3;
	localparam int STEP_FW  = 20;
	localparam int OFF_FW   = 10;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 20;

	// transaction modes
	localparam logic [MODE_FW-1:0] MODE_RULE   = 3'd0;
	localparam logic [MODE_FW-1:0] MODE_KIND   = 3'd1;
	localparam logic [MODE_FW-1:0] MODE_APPEND = 3'd2;
	localparam logic [MODE_FW-1:0] MODE_RUN    = 3'd3;
	localparam logic [MODE_FW-1:0] MODE_READ   = 3'd4;

	// verdicts
	localparam logic [VERD_FW-1:0] VERD_ACCEPT  = 3'd0;
	localparam logic [VERD_FW-1:0] VERD_REJECT  = 3'd1;
	localparam logic [VERD_FW-1:0] VERD_NO_RULE = 3'd2;
	localparam logic [VERD_FW-1:0] VERD_LIMIT   = 3'd3;
	localparam logic [VERD_FW-1:0] VERD_BOUND   = 3'd4;

	// head moves (code three behaves as stay)
	localparam logic [MOVE_FW-1:0] MV_LEFT  = 2'd1;
	localparam logic [MOVE_FW-1:0] MV_RIGHT = 2'd2;

	// state kind bits
	localparam int KIND_ACC_BIT = 0;
	localparam int KIND_REJ_BIT = 1;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BLANK = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_LIMIT = 2'd2;

	typedef struct packed {
		logic                   valid;
		logic [STATE_W-1:0]     target;
		logic [SYMBOL_BITS-1:0] wsym;
		logic [MOVE_FW-1:0]     mv;
	} rule_t;

	typedef struct packed {
		logic re;    // read at raddr
		logic we;    // write at waddr
		logic wclr;  // write marks the cell unwritten
	} tape_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/tmr_tape.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_tape
// Tape memory with epoch tags, same-cycle write forwarding and blank fill.
// ----------------------------------------------------------------------------
module tmr_tape
	import tmr_pkg::*;
#(
	parameter int TAPE_CELLS = TAPE_CELLS_DEF,
	localparam int TIDX_W    = $clog2(TAPE_CELLS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire tape_ctl_t              ctl,
	input  wire logic [TIDX_W-1:0]      raddr,
	input  wire logic [TIDX_W-1:0]      waddr,
	input  wire logic [SYMBOL_BITS-1:0] wsym,
	input  wire logic [EPOCH_BITS-1:0]  epoch,
	input  wire logic [SYMBOL_BITS-1:0] blank,
	output logic      [SYMBOL_BITS-1:0] rsym
);

	typedef struct packed {
		logic [EPOCH_BITS-1:0]  tag;
		logic [SYMBOL_BITS-1:0] sym;
	} cell_t;

	cell_t                  mem [TAPE_CELLS];
	cell_t                  rd_q;
	logic                   fwd_q;
	logic [SYMBOL_BITS-1:0] fwd_sym_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= '{tag: (ctl.wclr ? '0 : epoch), sym: wsym};
		end
		if (ctl.re) begin
			rd_q <= mem[raddr];
		end
		fwd_sym_q <= wsym;
	end

	// read and write on one cell in one cycle: memory returns the old cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.re) begin
			fwd_q <= ctl.we && !ctl.wclr && (raddr == waddr);
		end
	end

	always_comb begin
		if (fwd_q) begin
			rsym = fwd_sym_q;
		end else if (rd_q.tag == epoch) begin
			rsym = rd_q.sym;
		end else begin
			rsym = blank;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/turing_machine_runner_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// turing_machine_runner_top
// Single-tape Turing machine: rule and tape memories with a stepping sequencer.
// ----------------------------------------------------------------------------
// Transactions load rules and state kinds, append input symbols, start a run
// or read one tape cell; runs and reads return one result transaction. A load
// is taken in, then written in the decode state. A run does, per transition,
// one tape read and one rule read on the single read port of each memory; it
// is bounded by the step limit. A read issues the tape read in the decode
// state and takes the cell in the read state. A tape clear advances the epoch
// tag kept with every cell, except every 63rd, which sweeps the tape. After
// reset the block clears the rule and tape memories, max(4096, TAPE_CELLS)
// addresses, and holds in_stall high meanwhile; configuration writes are taken
// throughout. A finished result waits in the output register while the next
// transaction is taken in.
// ----------------------------------------------------------------------------
module turing_machine_runner_top
	import tmr_pkg::*;
#(
	parameter int TAPE_CELLS = TAPE_CELLS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IW-1:0]        cfg_index,
	input  wire logic [CFG_DW-1:0]        cfg_data,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [MODE_FW-1:0]       mode,
	input  wire logic [STATE_FW-1:0]      state_index,
	input  wire logic [SYM_FW-1:0]        symbol,
	input  wire logic [STATE_FW-1:0]      target_state,
	input  wire logic [SYM_FW-1:0]        write_value,
	input  wire logic [MOVE_FW-1:0]       move,
	input  wire logic                     entry_valid,
	input  wire logic [KIND_FW-1:0]       state_kind,
	input  wire logic                     clear_tape,
	input  wire logic signed [OFF_FW-1:0] cell_offset,
	// output channel
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [VERD_FW-1:0]            verdict,
	output logic [STATE_FW-1:0]           final_state,
	output logic [STEP_FW-1:0]            steps_taken,
	output logic signed [OFF_FW-1:0]      head_offset,
	output logic [SYM_FW-1:0]             cell_symbol
);

	localparam int TIDX_W  = $clog2(TAPE_CELLS);
	localparam int HALF    = TAPE_CELLS / 2;
	localparam int SWEEP_N = (RULE_DEPTH > TAPE_CELLS) ? RULE_DEPTH : TAPE_CELLS;
	localparam int SW_W    = $clog2(SWEEP_N);
	localparam int APP_W   = TIDX_W + 1;
	localparam int RW      = ((TIDX_W > OFF_FW) ? TIDX_W : OFF_FW) + 2;
	localparam int HO_W    = ((TIDX_W + 1) > OFF_FW) ? (TIDX_W + 1) : OFF_FW;

	typedef enum logic [6:0] {
		S_SWEEP   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_DECODE  = 7'b0000100,
		S_RULE_RD = 7'b0001000,
		S_APPLY   = 7'b0010000,
		S_READ    = 7'b0100000,
		S_EMIT    = 7'b1000000
	} fsm_t;

	fsm_t fsm_q;

	// configuration registers
	logic [STATE_W-1:0]     start_q;
	logic [SYMBOL_BITS-1:0] blank_q;
	logic [STEP_BITS-1:0]   limit_q;

	// latched transaction
	logic [MODE_FW-1:0]     mode_q;
	logic [STATE_W-1:0]     sidx_q;
	logic [SYMBOL_BITS-1:0] isym_q;
	logic [STATE_W-1:0]     itarget_q;
	logic [SYMBOL_BITS-1:0] iwval_q;
	logic [MOVE_FW-1:0]     imove_q;
	logic                   ivalid_q;
	logic [KIND_FW-1:0]     ikind_q;
	logic                   clr_q;
	logic signed [OFF_FW-1:0] coff_q;

	// machine state
	logic [KIND_FW-1:0]     kind_q [NUM_STATES];
	logic [STATE_W-1:0]     state_q;
	logic [TIDX_W-1:0]      head_q;
	logic [STEP_BITS-1:0]   count_q;
	logic [APP_W-1:0]       app_q;
	logic [EPOCH_BITS-1:0]  epoch_q;
	logic [SW_W-1:0]        sw_q;
	logic                   sweep_rules_q;
	logic                   in_range_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [VERD_FW-1:0]     res_verd_q;
	logic [SYMBOL_BITS-1:0] res_sym_q;

	// output register
	logic                   out_valid_q;
	logic [VERD_FW-1:0]     out_verd_q;
	logic [STATE_FW-1:0]    out_state_q;
	logic [STEP_FW-1:0]     out_steps_q;
	logic [OFF_FW-1:0]      out_head_q;
	logic [SYM_FW-1:0]      out_sym_q;

	// rule memory
	rule_t                  rule_mem [RULE_DEPTH];
	rule_t                  rule_q;
	logic                   rule_re;
	logic                   rule_we;
	logic [RULE_AW-1:0]     rule_raddr;
	logic [RULE_AW-1:0]     rule_waddr;
	rule_t                  rule_wdata;

	// tape port
	tape_ctl_t              tctl;
	logic [TIDX_W-1:0]      t_raddr;
	logic [TIDX_W-1:0]      t_waddr;
	logic [SYMBOL_BITS-1:0] t_wsym;
	logic [SYMBOL_BITS-1:0] t_rsym;

	// decode helpers
	logic                   in_accept;
	logic                   do_clr;
	logic                   app_room;
	logic                   sw_rule_on;
	logic                   sw_tape_on;
	logic                   sw_done;
	logic signed [RW-1:0]   rd_wide;
	logic                   rd_in;
	logic                   limit_hit;
	logic [KIND_FW-1:0]     cur_kind;
	logic                   off_tape;
	logic [TIDX_W-1:0]      next_head;
	logic                   out_free;
	logic [HO_W-1:0]        head_off;

	assign in_stall  = (fsm_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign do_clr    = clr_q;
	assign app_room  = app_q < APP_W'(TAPE_CELLS);
	assign out_free  = !out_valid_q || !out_stall;

	assign sw_rule_on = sweep_rules_q && ({1'b0, sw_q} < (SW_W + 1)'(RULE_DEPTH));
	assign sw_tape_on = {1'b0, sw_q} < (SW_W + 1)'(TAPE_CELLS);
	assign sw_done    = sw_q == (sweep_rules_q ? SW_W'(SWEEP_N - 1) : SW_W'(TAPE_CELLS - 1));

	// mode 4 cell position as a tape index, with bounds test
	assign rd_wide = RW'(coff_q) + RW'(HALF);
	assign rd_in   = !rd_wide[RW-1] && (rd_wide < RW'(TAPE_CELLS));

	assign limit_hit = count_q >= limit_q;
	assign cur_kind  = kind_q[state_q];

	// head move of the rule just read; leaving the tape keeps the head on the edge
	always_comb begin
		off_tape  = 1'b0;
		next_head = head_q;
		if (rule_q.mv == MV_LEFT) begin
			off_tape  = (head_q == '0);
			next_head = head_q - 1'b1;
		end else if (rule_q.mv == MV_RIGHT) begin
			off_tape  = (head_q == TIDX_W'(TAPE_CELLS - 1));
			next_head = head_q + 1'b1;
		end
	end

	// memory port control
	always_comb begin
		tctl       = '0;
		t_raddr    = head_q;
		t_waddr    = head_q;
		t_wsym     = rule_q.wsym;
		rule_re    = 1'b0;
		rule_we    = 1'b0;
		rule_raddr = {state_q, t_rsym};
		rule_waddr = {sidx_q, isym_q};
		rule_wdata = '{valid: ivalid_q, target: itarget_q, wsym: iwval_q, mv: imove_q};
		case (fsm_q)
			S_SWEEP: begin
				tctl.we    = sw_tape_on;
				tctl.wclr  = 1'b1;
				t_waddr    = sw_q[TIDX_W-1:0];
				rule_we    = sw_rule_on;
				rule_waddr = sw_q[RULE_AW-1:0];
				rule_wdata = '0;
			end
			S_DECODE: begin
				if (!do_clr) begin
					case (mode_q)
						MODE_RULE: begin
							rule_we = 1'b1;
						end
						MODE_APPEND: begin
							tctl.we = app_room;
							t_waddr = app_q[TIDX_W-1:0];
							t_wsym  = isym_q;
						end
						MODE_RUN: begin
							tctl.re = 1'b1;
							t_raddr = TIDX_W'(HALF);
						end
						MODE_READ: begin
							tctl.re = 1'b1;
							t_raddr = rd_wide[TIDX_W-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			S_RULE_RD: begin
				rule_re = !limit_hit && !cur_kind[KIND_ACC_BIT] && !cur_kind[KIND_REJ_BIT];
			end
			S_APPLY: begin
				if (rule_q.valid) begin
					tctl.we = 1'b1;
					tctl.re = !off_tape;
					t_raddr = next_head;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[rule_waddr] <= rule_wdata;
		end
		if (rule_re) begin
			rule_q <= rule_mem[rule_raddr];
		end
	end

	tmr_tape #(
		.TAPE_CELLS (TAPE_CELLS)
	) u_tape (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.raddr  (t_raddr),
		.waddr  (t_waddr),
		.wsym   (t_wsym),
		.epoch  (epoch_q),
		.blank  (blank_q),
		.rsym   (t_rsym)
	);

	// configuration writes, taken in any state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			blank_q <= SYMBOL_BITS'(95);
			limit_q <= STEP_BITS'(10000);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START: start_q <= cfg_data[STATE_W-1:0];
				CFG_BLANK: blank_q <= cfg_data[SYMBOL_BITS-1:0];
				CFG_LIMIT: limit_q <= cfg_data[STEP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// latched transaction payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q    <= mode;
			sidx_q    <= state_index[STATE_W-1:0];
			isym_q    <= symbol[SYMBOL_BITS-1:0];
			itarget_q <= target_state[STATE_W-1:0];
			iwval_q   <= write_value[SYMBOL_BITS-1:0];
			imove_q   <= move;
			ivalid_q  <= entry_valid;
			ikind_q   <= state_kind;
			coff_q    <= cell_offset;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q         <= S_SWEEP;
			sweep_rules_q <= 1'b1;
			sw_q          <= '0;
			clr_q         <= 1'b0;
			epoch_q       <= EPOCH_BITS'(1);
			app_q         <= APP_W'(HALF);
			state_q       <= '0;
			head_q        <= TIDX_W'(HALF);
			count_q       <= '0;
			in_range_q    <= 1'b0;
			sym_q         <= '0;
			res_verd_q    <= VERD_ACCEPT;
			res_sym_q     <= '0;
			for (int i = 0; i < NUM_STATES; i++) begin
				kind_q[i] <= '0;
			end
		end else begin
			case (fsm_q)
				S_SWEEP: begin
					sw_q <= sw_q + 1'b1;
					if (sw_done) begin
						sw_q          <= '0;
						sweep_rules_q <= 1'b0;
						if (sweep_rules_q) begin
							fsm_q <= S_IDLE;
						end else begin
							// epoch wrap: tags are all zero again
							epoch_q <= EPOCH_BITS'(1);
							app_q   <= APP_W'(HALF);
							clr_q   <= 1'b0;
							fsm_q   <= S_DECODE;
						end
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						clr_q <= clear_tape && (mode == MODE_APPEND || mode == MODE_RUN);
						fsm_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (do_clr) begin
						if (&epoch_q) begin
							fsm_q <= S_SWEEP;
						end else begin
							epoch_q <= epoch_q + 1'b1;
							app_q   <= APP_W'(HALF);
							clr_q   <= 1'b0;
						end
					end else begin
						fsm_q <= S_IDLE;
						case (mode_q)
							MODE_KIND: begin
								kind_q[sidx_q] <= ikind_q;
							end
							MODE_APPEND: begin
								if (app_room) begin
									app_q <= app_q + 1'b1;
								end
							end
							MODE_RUN: begin
								state_q <= start_q;
								head_q  <= TIDX_W'(HALF);
								count_q <= '0;
								fsm_q   <= S_RULE_RD;
							end
							MODE_READ: begin
								in_range_q <= rd_in;
								fsm_q      <= S_READ;
							end
							default: begin
							end
						endcase
					end
				end
				S_RULE_RD: begin
					// limit before the kind tests, accept before reject
					sym_q     <= t_rsym;
					res_sym_q <= t_rsym;
					if (limit_hit) begin
						res_verd_q <= VERD_LIMIT;
						fsm_q      <= S_EMIT;
					end else if (cur_kind[KIND_ACC_BIT]) begin
						res_verd_q <= VERD_ACCEPT;
						fsm_q      <= S_EMIT;
					end else if (cur_kind[KIND_REJ_BIT]) begin
						res_verd_q <= VERD_REJECT;
						fsm_q      <= S_EMIT;
					end else begin
						fsm_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (!rule_q.valid) begin
						res_verd_q <= VERD_NO_RULE;
						res_sym_q  <= sym_q;
						fsm_q      <= S_EMIT;
					end else begin
						state_q <= rule_q.target;
						count_q <= count_q + 1'b1;
						if (off_tape) begin
							res_verd_q <= VERD_BOUND;
							res_sym_q  <= rule_q.wsym;
							fsm_q      <= S_EMIT;
						end else begin
							head_q <= next_head;
							fsm_q  <= S_RULE_RD;
						end
					end
				end
				S_READ: begin
					res_verd_q <= VERD_ACCEPT;
					res_sym_q  <= in_range_q ? t_rsym : blank_q;
					fsm_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						fsm_q <= S_IDLE;
					end
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	// head index back to an offset from the first input cell
	assign head_off = HO_W'(head_q) - HO_W'(HALF);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fsm_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fsm_q == S_EMIT && out_free) begin
			out_verd_q  <= res_verd_q;
			out_state_q <= STATE_FW'(state_q);
			out_steps_q <= STEP_FW'(count_q);
			out_head_q  <= head_off[OFF_FW-1:0];
			out_sym_q   <= SYM_FW'(res_sym_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = out_verd_q;
	assign final_state = out_state_q;
	assign steps_taken = out_steps_q;
	assign head_offset = out_head_q;
	assign cell_symbol = out_sym_q;

endmodule
`default_nettype wire

@@ bench/tmr_run_checker.sv @@
// ----------------------------------------------------------------------------
// tmr_run_checker
// Watches the Turing machine runner and checks every result transaction.
// ----------------------------------------------------------------------------
// Holds its own copy of the rule, kind and tape stores and of the register
// settings. It replays each accepted input transaction and queues the outcome
// of runs and cell reads. Each result is then compared field by field with the
// oldest outcome waiting.
// ----------------------------------------------------------------------------
module tmr_run_checker
	import tmr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IW-1:0]        cfg_index,
	input  logic [CFG_DW-1:0]        cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [MODE_FW-1:0]       mode,
	input  logic [STATE_FW-1:0]      state_index,
	input  logic [SYM_FW-1:0]        symbol,
	input  logic [STATE_FW-1:0]      target_state,
	input  logic [SYM_FW-1:0]        write_value,
	input  logic [MOVE_FW-1:0]       move,
	input  logic                     entry_valid,
	input  logic [KIND_FW-1:0]       state_kind,
	input  logic                     clear_tape,
	input  logic signed [OFF_FW-1:0] cell_offset,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [VERD_FW-1:0]       verdict,
	input  logic [STATE_FW-1:0]      final_state,
	input  logic [STEP_FW-1:0]       steps_taken,
	input  logic signed [OFF_FW-1:0] head_offset,
	input  logic [SYM_FW-1:0]        cell_symbol,
	output int                       fail_count,
	output int                       pending,
	output int                       results_checked,
	output logic [VERD_BOUND:0]      verdicts_hit
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPE_N     = TAPE_CELLS_DEF;
	localparam int TAPE_LO    = -(TAPE_N / 2);
	localparam int TAPE_HI    = TAPE_N - TAPE_N / 2 - 1;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [VERD_FW-1:0]  verdict;
		logic [STATE_FW-1:0] fstate;
		logic [STEP_FW-1:0]  steps;
		logic [OFF_FW-1:0]   head;
		logic [SYM_FW-1:0]   sym;
	} outcome_t;

	rule_t               rules [RULE_DEPTH];
	logic [KIND_FW-1:0]  kinds [NUM_STATES];
	logic                cell_set [TAPE_N];
	logic [SYM_FW-1:0]   cell_val [TAPE_N];
	int                  fill_ptr;
	logic [STATE_FW-1:0] cur_state;
	int                  head_pos;
	int unsigned         step_count;

	logic [STATE_FW-1:0] start_reg;
	logic [SYM_FW-1:0]   blank_reg;
	int unsigned         limit_reg;

	outcome_t outcomes_due [$];

	task automatic report_mismatch(input string what);
		if (fail_count < MAX_PRINTS)
			$display("[%0t] checker: %s", $time, what);
		fail_count++;
	endtask

	function automatic logic [SYM_FW-1:0] tape_at(input int pos);
		if (pos < TAPE_LO || pos > TAPE_HI)
			return blank_reg;
		if (!cell_set[pos - TAPE_LO])
			return blank_reg;
		return cell_val[pos - TAPE_LO];
	endfunction

	function automatic void tape_put(input int pos, input logic [SYM_FW-1:0] sym);
		if (pos >= TAPE_LO && pos <= TAPE_HI) begin
			cell_set[pos - TAPE_LO] = 1'b1;
			cell_val[pos - TAPE_LO] = sym;
		end
	endfunction

	function automatic void tape_wipe();
		for (int i = 0; i < TAPE_N; i++)
			cell_set[i] = 1'b0;
		fill_ptr = 0;
	endfunction

	// steps the machine from the start state; stop tests come in this order
	function automatic logic [VERD_FW-1:0] simulate_run();
		logic [KIND_FW-1:0] k;
		rule_t              r;
		int                 nxt;
		cur_state  = start_reg;
		head_pos   = 0;
		step_count = 0;
		while (step_count < limit_reg) begin
			k = kinds[cur_state];
			if (k[KIND_ACC_BIT])
				return VERD_ACCEPT;
			if (k[KIND_REJ_BIT])
				return VERD_REJECT;
			r = rules[{cur_state, tape_at(head_pos)}];
			if (!r.valid)
				return VERD_NO_RULE;
			tape_put(head_pos, r.wsym);
			cur_state = r.target;
			step_count++;
			nxt = head_pos;
			if (r.mv == MV_LEFT)
				nxt--;
			else if (r.mv == MV_RIGHT)
				nxt++;
			if (nxt < TAPE_LO || nxt > TAPE_HI)
				return VERD_BOUND;
			head_pos = nxt;
		end
		return VERD_LIMIT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t           due;
		outcome_t           seen;
		logic [VERD_FW-1:0] v;
		int                 pos;
		if (!arst_n) begin
			for (int i = 0; i < RULE_DEPTH; i++)
				rules[i] = '0;
			for (int i = 0; i < NUM_STATES; i++)
				kinds[i] = '0;
			tape_wipe();
			cur_state       = '0;
			head_pos        = 0;
			step_count      = 0;
			start_reg       = '0;
			blank_reg       = 8'd95;
			limit_reg       = 10000;
			outcomes_due    = {};
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
			verdicts_hit    = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START: start_reg = cfg_data[STATE_FW-1:0];
					CFG_BLANK: blank_reg = cfg_data[SYM_FW-1:0];
					CFG_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (mode)
					MODE_RULE: begin
						rules[{state_index, symbol}] =
							{entry_valid, target_state, write_value, move};
					end
					MODE_KIND: kinds[state_index] = state_kind;
					MODE_APPEND: begin
						if (clear_tape)
							tape_wipe();
						if (fill_ptr <= TAPE_HI) begin
							tape_put(fill_ptr, symbol);
							fill_ptr++;
						end
					end
					MODE_RUN: begin
						if (clear_tape)
							tape_wipe();
						v   = simulate_run();
						due = {v, cur_state, step_count[STEP_FW-1:0],
							head_pos[OFF_FW-1:0], tape_at(head_pos)};
						outcomes_due.push_back(due);
					end
					MODE_READ: begin
						pos = cell_offset;
						due = {VERD_ACCEPT, cur_state, step_count[STEP_FW-1:0],
							head_pos[OFF_FW-1:0], tape_at(pos)};
						outcomes_due.push_back(due);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = {verdict, final_state, steps_taken, head_offset, cell_symbol};
				if (outcomes_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding (verdict %0d)",
						verdict));
				end else begin
					due = outcomes_due.pop_front();
					results_checked++;
					if (due.verdict <= VERD_BOUND)
						verdicts_hit[due.verdict] = 1'b1;
					if (seen.verdict !== due.verdict)
						report_mismatch($sformatf("verdict %0d, expected %0d",
							seen.verdict, due.verdict));
					if (seen.fstate !== due.fstate)
						report_mismatch($sformatf("final_state %0d, expected %0d",
							seen.fstate, due.fstate));
					if (seen.steps !== due.steps)
						report_mismatch($sformatf("steps_taken %0d, expected %0d",
							seen.steps, due.steps));
					if (seen.head !== due.head)
						report_mismatch($sformatf("head_offset %0d, expected %0d",
							$signed(seen.head), $signed(due.head)));
					if (seen.sym !== due.sym)
						report_mismatch($sformatf("cell_symbol %0d, expected %0d",
							seen.sym, due.sym));
				end
			end
			pending = outcomes_due.size();
		end
	end

endmodule

@@ bench/tb_turing_machine_runner_top.sv @@
// ----------------------------------------------------------------------------
// tb_turing_machine_runner_top
// Stimulus and verdict for the Turing machine runner.
// ----------------------------------------------------------------------------
// A short directed opening covers empty-table runs, accept/reject/both kinds,
// walks off either end of the tape, rule removal, the odd move code, unused
// modes and reads at the tape extremes. Random episodes then load small
// machines over a few-symbol alphabet, append input, run and read back, under
// a sequence of register settings. Checking is done by tmr_run_checker.
// ----------------------------------------------------------------------------
module tb_turing_machine_runner_top
	import tmr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int CYCLE_LIMIT   = 3_000_000;
	// room for a full tape sweep, which a clear can trigger without any result
	localparam int SETTLE_CYCLES = TAPE_CELLS_DEF + 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int NUM_PHASES    = 7;
	localparam int PHASE_ITEMS   = 150;
	localparam int FILL_ITEMS    = 520;
	localparam int PRESSURE_READS = 12;

	localparam logic [SYM_FW-1:0]  BLANK_RESET = 8'd95;
	localparam logic [STEP_FW-1:0] LIMIT_MAX   = '1;

	localparam logic [MOVE_FW-1:0] MV_STAY = 2'd0;
	localparam logic [MOVE_FW-1:0] MV_ODD  = 2'd3;   // behaves as stay

	localparam logic [KIND_FW-1:0] KIND_NORMAL = 2'd0;
	localparam logic [KIND_FW-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KIND_FW-1:0] KIND_REJECT = 2'd2;
	localparam logic [KIND_FW-1:0] KIND_BOTH   = 2'd3;

	// one input transaction, every field kept whether the mode uses it or not
	typedef struct packed {
		logic [MODE_FW-1:0]  mode;
		logic [STATE_FW-1:0] sidx;
		logic [SYM_FW-1:0]   sym;
		logic [STATE_FW-1:0] tgt;
		logic [SYM_FW-1:0]   wval;
		logic [MOVE_FW-1:0]  mv;
		logic                ev;
		logic [KIND_FW-1:0]  kind;
		logic                clr;
		logic [OFF_FW-1:0]   off;
	} tm_txn_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IW-1:0]        cfg_index = '0;
	logic [CFG_DW-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [MODE_FW-1:0]       mode = '0;
	logic [STATE_FW-1:0]      state_index = '0;
	logic [SYM_FW-1:0]        symbol = '0;
	logic [STATE_FW-1:0]      target_state = '0;
	logic [SYM_FW-1:0]        write_value = '0;
	logic [MOVE_FW-1:0]       move = '0;
	logic                     entry_valid = 1'b0;
	logic [KIND_FW-1:0]       state_kind = '0;
	logic                     clear_tape = 1'b0;
	logic signed [OFF_FW-1:0] cell_offset = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [VERD_FW-1:0]       verdict;
	logic [STATE_FW-1:0]      final_state;
	logic [STEP_FW-1:0]       steps_taken;
	logic signed [OFF_FW-1:0] head_offset;
	logic [SYM_FW-1:0]        cell_symbol;

	int                  fail_count;
	int                  pending;
	int                  results_checked;
	logic [VERD_BOUND:0] verdicts_hit;

	// stimulus bookkeeping
	bit                  calm = 1'b0;       // no idling on either side
	bit                  hold_req = 1'b0;   // asks the receiver for a long hold-off
	int                  items_sent = 0;    // transactions the block acts on
	int                  n_loads = 0;
	int                  n_runs = 0;
	int                  n_reads = 0;
	int                  n_ignored = 0;
	logic [STATE_FW-1:0] start_now = '0;
	logic [SYM_FW-1:0]   blank_now = BLANK_RESET;
	logic [STEP_FW-1:0]  limit_now = '0;
	int unsigned         cycle_count = 0;

	turing_machine_runner_top dut (.*);

	tmr_run_checker watcher (.*);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake or a runaway run ends here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[%0t] no finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("turing_machine_runner_top: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts, or one long hold-off on request so the
	// block fills up and pushes back on its input. One assignment per edge.
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Transaction builders. Fields a mode ignores stay random, so every bit of
	// every field gets toggled over the run.
	// ------------------------------------------------------------------------
	function automatic tm_txn_t any_txn();
		tm_txn_t t;
		t.mode = $urandom_range(0, (1 << MODE_FW) - 1);
		t.sidx = $urandom;
		t.sym  = $urandom;
		t.tgt  = $urandom;
		t.wval = $urandom;
		t.mv   = $urandom;
		t.ev   = $urandom;
		t.kind = $urandom;
		t.clr  = $urandom;
		t.off  = $urandom;
		return t;
	endfunction

	function automatic tm_txn_t rule_txn(input logic [STATE_FW-1:0] s,
		input logic [SYM_FW-1:0] sym, input logic [STATE_FW-1:0] tgt,
		input logic [SYM_FW-1:0] wval, input logic [MOVE_FW-1:0] mv,
		input logic ev);
		tm_txn_t t;
		t      = any_txn();
		t.mode = MODE_RULE;
		t.sidx = s;
		t.sym  = sym;
		t.tgt  = tgt;
		t.wval = wval;
		t.mv   = mv;
		t.ev   = ev;
		return t;
	endfunction

	function automatic tm_txn_t kind_txn(input logic [STATE_FW-1:0] s,
		input logic [KIND_FW-1:0] k);
		tm_txn_t t;
		t      = any_txn();
		t.mode = MODE_KIND;
		t.sidx = s;
		t.kind = k;
		return t;
	endfunction

	function automatic tm_txn_t append_txn(input logic [SYM_FW-1:0] sym, input logic clr);
		tm_txn_t t;
		t      = any_txn();
		t.mode = MODE_APPEND;
		t.sym  = sym;
		t.clr  = clr;
		return t;
	endfunction

	function automatic tm_txn_t run_txn(input logic clr);
		tm_txn_t t;
		t      = any_txn();
		t.mode = MODE_RUN;
		t.clr  = clr;
		return t;
	endfunction

	function automatic tm_txn_t read_txn(input int pos);
		tm_txn_t t;
		t      = any_txn();
		t.mode = MODE_READ;
		t.off  = pos[OFF_FW-1:0];
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: optional idle burst, then the transaction is held until the
	// block takes it (valid high, stall low at a rising edge).
	// ------------------------------------------------------------------------
	task automatic send(input tm_txn_t t);
		if (!calm && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		mode         <= t.mode;
		state_index  <= t.sidx;
		symbol       <= t.sym;
		target_state <= t.tgt;
		write_value  <= t.wval;
		move         <= t.mv;
		entry_valid  <= t.ev;
		state_kind   <= t.kind;
		clear_tape   <= t.clr;
		cell_offset  <= t.off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (t.mode)
			MODE_RULE, MODE_KIND, MODE_APPEND: n_loads++;
			MODE_RUN:  n_runs++;
			MODE_READ: n_reads++;
			default:   n_ignored++;
		endcase
		if (t.mode <= MODE_READ)
			items_sent++;
	endtask

	// sender goes quiet until every result is back and any sweep has finished
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// One episode: a small machine over states including the start state and
	// a three-symbol alphabet (blank plus two), then input, a run and reads.
	// A halting episode moves right on every rule, clears the tape first and
	// defines or removes every pair, so a run ends within one tape length even
	// under the largest step limit. Otherwise some pairs stay undefined and
	// stray random transactions are mixed in.
	// ------------------------------------------------------------------------
	task automatic play_episode(input bit halting);
		logic [STATE_FW-1:0] states [4];
		logic [SYM_FW-1:0]   alpha [3];
		int                  n_states;
		int                  n_app;
		int                  n_reads_ep;
		logic [MOVE_FW-1:0]  mv;
		logic [KIND_FW-1:0]  kind;
		logic                clr;
		n_states  = $urandom_range(1, 4);
		states[0] = start_now;
		for (int i = 1; i < 4; i++)
			states[i] = $urandom;
		alpha[0] = blank_now;
		alpha[1] = $urandom;
		alpha[2] = $urandom;

		for (int i = 0; i < n_states; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!halting && $urandom_range(0, 9) == 0)
					continue;
				mv = halting ? MV_RIGHT : $urandom_range(0, 3);
				send(rule_txn(states[i], alpha[j], states[$urandom_range(0, n_states - 1)],
					alpha[$urandom_range(0, 2)], mv, $urandom_range(0, 7) != 0));
				if (!halting && $urandom_range(0, 9) == 0)
					send(any_txn());
			end
		end

		for (int i = 0; i < n_states; i++) begin
			kind = ($urandom_range(0, 9) < 6) ? KIND_NORMAL : $urandom_range(1, 3);
			send(kind_txn(states[i], kind));
		end

		n_app = $urandom_range(0, 10);
		for (int i = 0; i < n_app; i++) begin
			clr = (i == 0) ? (halting || $urandom_range(0, 3) != 0) : 1'b0;
			send(append_txn(alpha[$urandom_range(0, 2)], clr));
		end

		if (n_app == 0)
			clr = halting ? 1'b1 : $urandom_range(0, 1);
		else
			clr = !halting && $urandom_range(0, 7) == 0;
		send(run_txn(clr));

		n_reads_ep = $urandom_range(1, 3);
		for (int i = 0; i < n_reads_ep; i++) begin
			if ($urandom_range(0, 3) == 0)
				send(read_txn(int'($urandom_range(0, 1023)) - 512));
			else
				send(read_txn(int'($urandom_range(0, n_app + 8)) - 4));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int      phase_first;
		tm_txn_t t;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed opening, reset register values ---
		// nothing written yet: blank everywhere, held run state all zero
		send(read_txn(0));
		send(read_txn(-512));
		send(read_txn(511));
		// empty rule table: stops at once with no transition
		send(run_txn(1'b0));
		// a state marked both ways accepts; reject alone rejects
		send(kind_txn(0, KIND_BOTH));
		send(run_txn(1'b0));
		send(kind_txn(0, KIND_REJECT));
		send(run_txn(1'b0));
		send(kind_txn(0, KIND_NORMAL));
		// walk right over blanks until the head would leave the tape
		send(rule_txn(0, blank_now, 0, 8'hFF, MV_RIGHT, 1'b1));
		send(run_txn(1'b1));
		send(read_txn(511));
		// odd move code keeps the head in place, then an accept state
		send(rule_txn(0, blank_now, 1, 8'h07, MV_ODD, 1'b1));
		send(kind_txn(1, KIND_ACCEPT));
		send(run_txn(1'b1));
		// removed entry: no transition again
		send(rule_txn(0, blank_now, 0, 8'h00, MV_STAY, 1'b0));
		send(run_txn(1'b1));
		// walk left off the low end
		send(rule_txn(0, blank_now, 0, 8'h01, MV_LEFT, 1'b1));
		send(run_txn(1'b1));
		send(read_txn(-512));
		// unused modes are swallowed without a result
		for (int m = MODE_READ + 1; m < (1 << MODE_FW); m++) begin
			t      = any_txn();
			t.mode = m;
			send(t);
		end
		// append extremes onto a fresh tape and read them back
		send(append_txn(8'h00, 1'b1));
		send(append_txn(8'hFF, 1'b0));
		send(read_txn(0));
		send(read_txn(1));
		send(read_txn(2));
		drain();

		// --- random episodes under a series of register settings ---
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin start_now = 0;        blank_now = BLANK_RESET; limit_now = 300; end
				1: begin start_now = '1;       blank_now = 8'h00;       limit_now = 0;   end
				2: begin start_now = $urandom; blank_now = 8'hFF;       limit_now = 1;   end
				3: begin start_now = $urandom; blank_now = $urandom;    limit_now = LIMIT_MAX; end
				4: begin start_now = $urandom; blank_now = $urandom;    limit_now = 1023; end
				5: begin
					start_now = 0;
					blank_now = $urandom;
					limit_now = $urandom_range(2, 200);
				end
				default: begin
					start_now = $urandom;
					blank_now = $urandom;
					limit_now = 64;
				end
			endcase
			set_reg(CFG_START, start_now);
			set_reg(CFG_BLANK, blank_now);
			set_reg(CFG_LIMIT, limit_now);
			// the closing phase runs flat out on both sides
			calm        = (ph == NUM_PHASES - 1);
			phase_first = items_sent;

			if (ph == 0) begin
				// overfill the tape: appends past the high end are dropped
				for (int i = 0; i < FILL_ITEMS; i++)
					send(append_txn($urandom, i == 0));
				send(run_txn(1'b0));
				send(read_txn(511));
				send(read_txn(-512));
				send(read_txn(0));
				send(read_txn(int'($urandom_range(0, 1023)) - 512));
			end
			if (ph == 4) begin
				// receiver holds off while reads keep coming, so the block backs up
				hold_req = 1'b1;
				for (int i = 0; i < PRESSURE_READS; i++)
					send(read_txn(int'($urandom_range(0, 1023)) - 512));
			end

			while (items_sent - phase_first < PHASE_ITEMS)
				play_episode(ph == 3);
			drain();
		end

		$display("summary: %0d transactions (%0d loads, %0d runs, %0d reads, %0d ignored), %0d results checked",
			n_loads + n_runs + n_reads + n_ignored, n_loads, n_runs, n_reads, n_ignored,
			results_checked);
		$display("summary: %0d register settings incl. zero and full step limits, verdicts seen %b",
			NUM_PHASES, verdicts_hit);
		if (fail_count == 0 && pending == 0)
			$display("turing_machine_runner_top: match");
		else
			$display("turing_machine_runner_top: mismatch");
		$finish;
	end

endmodule
